// ===== hw/rtl/c_subset_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef C_SUBSET_TOKENIZER_DEFINES_SVH
`define C_SUBSET_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define CST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tokenizer assertion failed");

// Condition must never be true outside reset.
`define CST_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("tokenizer forbidden condition seen");

`else

`define CST_ASSERT(lbl, clk, rstn, prop)
`define CST_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== hw/rtl/cst_pkg.sv =====
// Shared types, token codes and character classes of the tokenizer.
// No dependencies; used by cst_kw_match and c_subset_tokenizer.
package cst_pkg;

  localparam int MAX_IDENT_LEN = 32;
  localparam int IDX_W = $clog2(MAX_IDENT_LEN);
  localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1);
  localparam int LINE_W = 20;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam int NUM_KW = 7;

  typedef logic [4:0] kind_t;

  localparam kind_t K_ADD    = 5'd0;
  localparam kind_t K_SUB    = 5'd1;
  localparam kind_t K_MUL    = 5'd2;
  localparam kind_t K_DIV    = 5'd3;
  localparam kind_t K_GT     = 5'd4;
  localparam kind_t K_GE     = 5'd5;
  localparam kind_t K_LT     = 5'd6;
  localparam kind_t K_LE     = 5'd7;
  localparam kind_t K_NOT    = 5'd8;
  localparam kind_t K_DEQU   = 5'd9;
  localparam kind_t K_EQU    = 5'd10;
  localparam kind_t K_SEMI   = 5'd11;
  localparam kind_t K_LBRACE = 5'd12;
  localparam kind_t K_RBRACE = 5'd13;
  localparam kind_t K_LPAR   = 5'd14;
  localparam kind_t K_RPAR   = 5'd15;
  localparam kind_t K_NUMBER = 5'd16;
  localparam kind_t K_IDENT  = 5'd17;
  localparam kind_t K_KW0    = 5'd18;
  localparam kind_t K_EOF    = 5'd25;
  localparam kind_t K_ERROR  = 5'd26;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Keyword table update request from the sequencer
  typedef struct packed {
    logic             start;
    logic             append;
    logic [IDX_W-1:0] pos;
    logic [7:0]       ch;
  } kw_upd_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } punct_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // One-character punctuators that complete at once
  function automatic punct_t single_punct(input logic [7:0] c);
    punct_t p;
    p.hit = 1'b1;
    unique case (c)
      "+":     p.kind = K_ADD;
      "-":     p.kind = K_SUB;
      "*":     p.kind = K_MUL;
      "/":     p.kind = K_DIV;
      "!":     p.kind = K_NOT;
      ";":     p.kind = K_SEMI;
      "{":     p.kind = K_LBRACE;
      "}":     p.kind = K_RBRACE;
      "(":     p.kind = K_LPAR;
      ")":     p.kind = K_RPAR;
      default: begin
        p.hit  = 1'b0;
        p.kind = K_ERROR;
      end
    endcase
    return p;
  endfunction

  // Keyword text, stored with the first character in the low byte
  function automatic logic [39:0] kw_text(input logic [2:0] k);
    logic [39:0] t;
    unique case (k)
      3'd0:    t = 40'("tnirp");
      3'd1:    t = 40'("tni");
      3'd2:    t = 40'("fi");
      3'd3:    t = 40'("esle");
      3'd4:    t = 40'("elihw");
      3'd5:    t = 40'("rof");
      3'd6:    t = 40'("diov");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] kw_len(input logic [2:0] k);
    logic [LEN_W-1:0] n;
    unique case (k)
      3'd0, 3'd4: n = LEN_W'(5);
      3'd1, 3'd5: n = LEN_W'(3);
      3'd2:       n = LEN_W'(2);
      3'd3, 3'd6: n = LEN_W'(4);
      default:    n = '0;
    endcase
    return n;
  endfunction

  // Keyword character at a position; zero past the end of the keyword
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [IDX_W-1:0] pos);
    logic [39:0] t;
    logic [7:0]  c;
    t = kw_text(k);
    c = 8'h00;
    for (int i = 0; i < 5; i++) begin
      if (32'(pos) == i) c = t[8*i +: 8];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the identifier characters of the tokenizer.
module cst_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cst_kw_match.sv =====
// Running keyword matcher: one candidate bit per keyword, narrowed per character.
// Depends on cst_pkg for the keyword table and the update struct.
module cst_kw_match (
  input  logic                        clk_i,
  input  cst_pkg::kw_upd_t            upd_i,
  input  logic [cst_pkg::LEN_W-1:0]   ident_len_i,
  input  logic                        ident_ovf_i,
  output logic                        kw_hit_o,
  output cst_pkg::kind_t              kw_kind_o
);

  logic [cst_pkg::NUM_KW-1:0] cand_q;
  logic [cst_pkg::NUM_KW-1:0] cand_d;
  logic [cst_pkg::NUM_KW-1:0] char_ok;

  // Compare the new character against every keyword at its position
  always_comb begin
    for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
      char_ok[k] = (cst_pkg::kw_char(3'(k), upd_i.pos) == upd_i.ch);
    end
  end

  // Restart on the first character, narrow on each further one
  always_comb begin
    cand_d = cand_q;
    if (upd_i.start) begin
      cand_d = char_ok;
    end else if (upd_i.append) begin
      cand_d = cand_q & char_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  // Pick the keyword whose characters and length both match
  always_comb begin
    kw_hit_o  = 1'b0;
    kw_kind_o = cst_pkg::K_IDENT;
    for (int k = cst_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (cand_q[k] && (cst_pkg::kw_len(3'(k)) == ident_len_i) && !ident_ovf_i) begin
        kw_hit_o  = 1'b1;
        kw_kind_o = cst_pkg::K_KW0 + 5'(k);
      end
    end
  end

endmodule

// ===== hw/rtl/c_subset_tokenizer.sv =====
// A byte ending a pending number, keyword or comparison loads it in ST_FLUSH; a
// one-byte punctuator, EOF or error in ST_POST after ST_FLUSH, the first name character
// in ST_ID after its RAM read. Input is one byte per cycle inside a token; it stalls
// in ST_FLUSH, ST_POST and ST_ID, which reads one RAM character per free output cycle.
// Reset: asynchronous, active low; line counter to one, block idle and unlocked.
// Top level of the tokenizer; depends on cst_pkg, cst_ram, cst_kw_match.
`include "c_subset_tokenizer_defines.svh"

module c_subset_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] int_value, [39:32] ident_char,
                                      // [59:40] line_number, [63:60] zero
  output logic        m_axis_tlast,   // last
  output logic [5:0]  m_axis_tuser    // [4:0] token_kind, [5] ident_truncated
);

  localparam int IW = cst_pkg::IDX_W;
  localparam int LW = cst_pkg::LEN_W;

  typedef enum logic [1:0] {ST_IN, ST_FLUSH, ST_ID, ST_POST} state_e;
  typedef enum logic [2:0] {
    MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_PUNCT, MODE_LOCKED
  } mode_e;
  typedef enum logic [1:0] {PO_NONE, PO_EOF, PO_START} post_e;

  state_e                     state_q, state_d;
  mode_e                      mode_q, mode_d;
  post_e                      post_q, post_d;
  logic [31:0]                num_q, num_d;
  logic [LW-1:0]              ident_len_q, ident_len_d;
  logic                       ident_ovf_q, ident_ovf_d;
  cst_pkg::kind_t             pend_q, pend_d;
  logic [cst_pkg::LINE_W-1:0] line_q, line_d;
  logic [IW-1:0]              rd_idx_q, rd_idx_d;
  logic [7:0]                 char_q, char_d;

  logic                       out_valid_q;
  cst_pkg::kind_t             out_kind_q, ld_kind;
  logic [31:0]                out_val_q, ld_val;
  logic [7:0]                 out_ch_q, ld_ch;
  logic                       out_last_q, ld_last;
  logic                       out_trunc_q, ld_trunc;
  logic [cst_pkg::LINE_W-1:0] out_line_q;
  logic                       out_load;
  logic                       slot_free;

  logic                       ram_we, ram_re;
  logic [IW-1:0]              ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, ram_rdata;
  cst_pkg::kw_upd_t           kw_upd;
  logic                       kw_hit;
  cst_pkg::kind_t             kw_kind;

  logic                       in_fire;
  logic [7:0]                 in_c;
  cst_pkg::punct_t            sp;

  assign s_axis_tready = (state_q == ST_IN);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_c          = s_axis_tdata;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign sp            = cst_pkg::single_punct(char_q);

  // Identifier buffer
  cst_ram #(
    .DEPTH(cst_pkg::MAX_IDENT_LEN),
    .WIDTH(8),
    .AW   (IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Keyword candidates, narrowed as characters are written
  cst_kw_match u_kw (
    .clk_i      (clk_i),
    .upd_i      (kw_upd),
    .ident_len_i(ident_len_q),
    .ident_ovf_i(ident_ovf_q),
    .kw_hit_o   (kw_hit),
    .kw_kind_o  (kw_kind)
  );

  // Sequencer: absorb bytes, flush the pending token, then start the next one.
  // RAM writes and reads never overlap: the walk ends before a new identifier starts.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    post_d      = post_q;
    num_d       = num_q;
    ident_len_d = ident_len_q;
    ident_ovf_d = ident_ovf_q;
    pend_d      = pend_q;
    line_d      = line_q;
    rd_idx_d    = rd_idx_q;
    char_d      = char_q;

    out_load = 1'b0;
    ld_kind  = cst_pkg::K_EOF;
    ld_val   = '0;
    ld_ch    = '0;
    ld_last  = 1'b1;
    ld_trunc = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = ident_len_q[IW-1:0];
    ram_wdata = in_c;
    ram_re    = 1'b0;
    ram_raddr = '0;

    kw_upd.start  = 1'b0;
    kw_upd.append = 1'b0;
    kw_upd.pos    = ident_len_q[IW-1:0];
    kw_upd.ch     = in_c;

    unique case (state_q)
      ST_IN: begin
        if (in_fire && (mode_q != MODE_LOCKED)) begin
          char_d = in_c;
          priority if (s_axis_tlast) begin
            post_d  = PO_EOF;
            state_d = ST_FLUSH;
          end else if ((mode_q == MODE_NUMBER) && cst_pkg::is_digit(in_c)) begin
            num_d = (num_q << 3) + (num_q << 1) + {28'd0, in_c[3:0]};
          end else if ((mode_q == MODE_IDENT) &&
                       (cst_pkg::is_alpha(in_c) || cst_pkg::is_digit(in_c))) begin
            if (ident_len_q < LW'(cst_pkg::MAX_IDENT_LEN)) begin
              ram_we        = 1'b1;
              kw_upd.append = 1'b1;
              ident_len_d   = ident_len_q + LW'(1);
            end else begin
              ident_ovf_d = 1'b1;
            end
          end else if ((mode_q == MODE_PUNCT) && (in_c == "=")) begin
            // Fold into a two-character token and emit it as the flush
            pend_d  = (pend_q == cst_pkg::K_EQU) ? cst_pkg::K_DEQU :
                      (pend_q == cst_pkg::K_LT)  ? cst_pkg::K_LE : cst_pkg::K_GE;
            post_d  = PO_NONE;
            state_d = ST_FLUSH;
          end else begin
            post_d  = PO_START;
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        unique case (mode_q)
          MODE_NUMBER: begin
            if (slot_free) begin
              out_load = 1'b1;
              ld_kind  = cst_pkg::K_NUMBER;
              ld_val   = num_q;
              mode_d   = MODE_IDLE;
              num_d    = '0;
              state_d  = ST_POST;
            end
          end
          MODE_PUNCT: begin
            if (slot_free) begin
              out_load = 1'b1;
              ld_kind  = pend_q;
              mode_d   = MODE_IDLE;
              pend_d   = '0;
              state_d  = ST_POST;
            end
          end
          MODE_IDENT: begin
            if (kw_hit) begin
              if (slot_free) begin
                out_load = 1'b1;
                ld_kind  = kw_kind;
                mode_d   = MODE_IDLE;
                state_d  = ST_POST;
              end
            end else begin
              // Fetch the first character; the walk emits one per cycle while the output slot is free
              ram_re    = 1'b1;
              ram_raddr = '0;
              rd_idx_d  = '0;
              state_d   = ST_ID;
            end
          end
          default: begin
            state_d = ST_POST;
          end
        endcase
      end

      ST_ID: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_kind  = cst_pkg::K_IDENT;
          ld_ch    = ram_rdata;
          ld_trunc = ident_ovf_q;
          ld_last  = ((LW'(rd_idx_q) + LW'(1)) == ident_len_q);
          if (ld_last) begin
            mode_d  = MODE_IDLE;
            state_d = ST_POST;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q + IW'(1);
            rd_idx_d  = rd_idx_q + IW'(1);
          end
        end
      end

      ST_POST: begin
        unique case (post_q)
          PO_EOF: begin
            if (slot_free) begin
              out_load = 1'b1;
              ld_kind  = cst_pkg::K_EOF;
              state_d  = ST_IN;
            end
          end
          PO_START: begin
            priority if ((char_q == cst_pkg::CH_SPACE) || (char_q == cst_pkg::CH_TAB)) begin
              state_d = ST_IN;
            end else if (char_q == cst_pkg::CH_LF) begin
              if (line_q != cst_pkg::LINE_MAX) line_d = line_q + cst_pkg::LINE_W'(1);
              state_d = ST_IN;
            end else if (cst_pkg::is_digit(char_q)) begin
              mode_d  = MODE_NUMBER;
              num_d   = {28'd0, char_q[3:0]};
              state_d = ST_IN;
            end else if (cst_pkg::is_alpha(char_q)) begin
              mode_d       = MODE_IDENT;
              ram_we       = 1'b1;
              ram_waddr    = '0;
              ram_wdata    = char_q;
              kw_upd.start = 1'b1;
              kw_upd.pos   = '0;
              kw_upd.ch    = char_q;
              ident_len_d  = LW'(1);
              ident_ovf_d  = 1'b0;
              state_d      = ST_IN;
            end else if ((char_q == "=") || (char_q == "<") || (char_q == ">")) begin
              mode_d  = MODE_PUNCT;
              pend_d  = (char_q == "=") ? cst_pkg::K_EQU :
                        (char_q == "<") ? cst_pkg::K_LT : cst_pkg::K_GT;
              state_d = ST_IN;
            end else if (sp.hit) begin
              if (slot_free) begin
                out_load = 1'b1;
                ld_kind  = sp.kind;
                state_d  = ST_IN;
              end
            end else begin
              // Unknown byte: report and lock until reset
              if (slot_free) begin
                out_load = 1'b1;
                ld_kind  = cst_pkg::K_ERROR;
                mode_d   = MODE_LOCKED;
                state_d  = ST_IN;
              end
            end
          end
          default: begin
            state_d = ST_IN;
          end
        endcase
      end

      default: begin
        state_d = ST_IN;
      end
    endcase
  end

  // Control state and lexer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IN;
      mode_q      <= MODE_IDLE;
      post_q      <= PO_NONE;
      num_q       <= '0;
      ident_len_q <= '0;
      ident_ovf_q <= 1'b0;
      pend_q      <= '0;
      line_q      <= cst_pkg::LINE_W'(1);
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      post_q      <= post_d;
      num_q       <= num_d;
      ident_len_q <= ident_len_d;
      ident_ovf_q <= ident_ovf_d;
      pend_q      <= pend_d;
      line_q      <= line_d;
      rd_idx_q    <= rd_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload and latched input byte
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (out_load) begin
      out_kind_q  <= ld_kind;
      out_val_q   <= ld_val;
      out_ch_q    <= ld_ch;
      out_last_q  <= ld_last;
      out_trunc_q <= ld_trunc;
      out_line_q  <= line_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_line_q, out_ch_q, out_val_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_trunc_q, out_kind_q};

  `CST_ASSERT(a_len_bound, clk_i, rst_ni, ident_len_q <= LW'(cst_pkg::MAX_IDENT_LEN))
  `CST_ASSERT(a_ovf_full, clk_i, rst_ni, ident_ovf_q |-> (ident_len_q == LW'(cst_pkg::MAX_IDENT_LEN)))
  `CST_ASSERT(a_walk_in_range, clk_i, rst_ni, (state_q == ST_ID) |-> (LW'(rd_idx_q) < ident_len_q))
  `CST_ASSERT(a_locked_silent, clk_i, rst_ni, ((mode_q == MODE_LOCKED) && (state_q == ST_IN)) |=> !out_load)
  `CST_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, out_load && out_valid_q && !m_axis_tready)

endmodule
